// ===== rtl/core/uidwl_pkg.sv =====
// ============================================================================
// uidwl_pkg
// Shared widths, codes and types of the card identifier table.
// ============================================================================
package uidwl_pkg;

    // Field widths of the request and response items
    localparam int CMD_W    = 2;
    localparam int LEN_W    = 4;
    localparam int LOW_W    = 64;
    localparam int HIGH_W   = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    // Identifier bytes carried by one item (low word plus high word)
    localparam int UID_BYTES = (LOW_W + HIGH_W) / 8;

    // Defaults of the top level parameters
    localparam int DEF_CAPACITY = 16;
    localparam int DEF_ID_BYTES = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One table entry: length and identifier bytes
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [HIGH_W-1:0] high;
        logic [LOW_W-1:0]  low;
    } entry_t;

endpackage

// ===== rtl/core/uidwl_req_if.sv =====
// ============================================================================
// uidwl_req_if
// Request channel of the identifier table: one command item per handshake.
// ============================================================================
interface uidwl_req_if;

    logic                        valid;
    logic                        ready;
    logic [uidwl_pkg::CMD_W-1:0] command;
    logic [uidwl_pkg::LEN_W-1:0] uid_length;
    logic [uidwl_pkg::LOW_W-1:0] uid_low;
    logic [uidwl_pkg::HIGH_W-1:0] uid_high;

    modport source (output valid, command, uid_length, uid_low, uid_high, input ready);
    modport sink   (input valid, command, uid_length, uid_low, uid_high, output ready);

endinterface

// ===== rtl/core/uidwl_rsp_if.sv =====
// ============================================================================
// uidwl_rsp_if
// Response channel of the identifier table: one result item per command.
// ============================================================================
interface uidwl_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [uidwl_pkg::STATUS_W-1:0] status;
    logic [uidwl_pkg::INDEX_W-1:0]  entry_index;
    logic [uidwl_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, status, entry_index, entry_count, input ready);
    modport sink   (input valid, status, entry_index, entry_count, output ready);

endinterface

// ===== rtl/core/uidwl_match.sv =====
// ============================================================================
// uidwl_match
// Shared entry comparator: length check plus masked byte compare.
// ============================================================================
module uidwl_match #(
    parameter int ID_BYTES = uidwl_pkg::DEF_ID_BYTES
) (
    input  uidwl_pkg::entry_t probe,
    input  uidwl_pkg::entry_t stored,
    output logic              hit
);

    localparam int NB = uidwl_pkg::UID_BYTES;

    logic [NB*8-1:0] probe_bytes;
    logic [NB*8-1:0] stored_bytes;
    logic [NB-1:0]   byte_ok;
    logic            len_ok;

    assign probe_bytes  = {probe.high, probe.low};
    assign stored_bytes = {stored.high, stored.low};

    // Ignore bytes at or beyond the length
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            byte_ok[b] = (probe_bytes[b*8 +: 8] == stored_bytes[b*8 +: 8]) ||
                         (uidwl_pkg::LEN_W'(b) >= probe.len);
        end
    end

    // A stored length of zero or above the byte limit never matches
    assign len_ok = (stored.len != '0) &&
                    (stored.len <= uidwl_pkg::LEN_W'(ID_BYTES)) &&
                    (stored.len == probe.len);

    assign hit = len_ok && (&byte_ok);

endmodule

// ===== rtl/core/uid_whitelist_table.sv =====
// ============================================================================
// uid_whitelist_table
// Table of card identifiers with lookup, add, delete and clear commands.
// ============================================================================
// Usage:
//   request carries one command item (command, uid_length, uid_low,
//   uid_high); response returns one result item (status, entry_index,
//   entry_count) for each command, in order.
//   A sequencer walks the stored entries through one shared comparator,
//   with a memory read, then a compare, for each entry. Delete then moves
//   every later entry down one slot, with a read, then a write, per moved
//   entry, through the single memory port.
//   Lookup, add and delete search at most the stored entries and stop at
//   the first match; clear searches nothing. request.ready is high only
//   between commands, so a new command is accepted only after the
//   sequencer has finished the previous one.
//   The result sits in an output register; a new command is accepted while
//   it waits. If the receiver stalls, the next result holds in the
//   sequencer until the output register frees up.
//   Reset empties the table (count zero); entry contents need no clearing.
// ============================================================================
module uid_whitelist_table #(
    parameter int CAPACITY = uidwl_pkg::DEF_CAPACITY,
    parameter int ID_BYTES = uidwl_pkg::DEF_ID_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    uidwl_req_if.sink   request,
    uidwl_rsp_if.source response
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_READ     = 7'b0000010,
        S_CMP      = 7'b0000100,
        S_RESOLVE  = 7'b0001000,
        S_SH_READ  = 7'b0010000,
        S_SH_WRITE = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     hit_reg, hit_next;
    uidwl_pkg::status_t       res_status_reg, res_status_next;
    logic [IDX_W-1:0]         res_index_reg, res_index_next;
    uidwl_pkg::cmd_t          cmd_reg;
    uidwl_pkg::entry_t        item_reg;
    uidwl_pkg::entry_t        rd_data_reg;

    logic                          out_valid_reg, out_valid_next;
    uidwl_pkg::status_t            out_status_reg, out_status_next;
    logic [uidwl_pkg::INDEX_W-1:0] out_index_reg, out_index_next;
    logic [uidwl_pkg::COUNT_W-1:0] out_count_reg, out_count_next;

    uidwl_pkg::entry_t mem [CAPACITY];

    logic              accept;
    logic              cmp_hit;
    logic              last;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    uidwl_pkg::entry_t wr_data;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;

    // No entry beyond the current pointer
    assign last = (CNT_W'(ptr_reg) + CNT_W'(1)) >= count_reg;

    // Shared comparator
    uidwl_match #(
        .ID_BYTES (ID_BYTES)
    ) u_match (
        .probe  (item_reg),
        .stored (rd_data_reg),
        .hit    (cmp_hit)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = item_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ptr_next = '0;
                    hit_next = 1'b0;
                    if (uidwl_pkg::cmd_t'(request.command) == uidwl_pkg::CMD_CLEAR)
                    begin
                        count_next      = '0;
                        res_status_next = uidwl_pkg::ST_OK;
                        res_index_next  = '0;
                        state_next      = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (cmp_hit)
                begin
                    hit_next   = 1'b1;
                    state_next = S_RESOLVE;
                end
                else if (last)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    ptr_next   = ptr_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end

            S_RESOLVE:
            begin
                res_index_next = '0;
                state_next     = S_DONE;
                case (cmd_reg)
                    uidwl_pkg::CMD_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = uidwl_pkg::ST_OK;
                            res_index_next  = ptr_reg;
                        end
                        else
                        begin
                            res_status_next = uidwl_pkg::ST_NOT_FOUND;
                        end
                    end
                    uidwl_pkg::CMD_ADD:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = uidwl_pkg::ST_DUPLICATE;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_status_next = uidwl_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[IDX_W-1:0];
                            res_status_next = uidwl_pkg::ST_OK;
                            res_index_next  = count_reg[IDX_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    uidwl_pkg::CMD_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = uidwl_pkg::ST_OK;
                            res_index_next  = ptr_reg;
                            if (last)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                ptr_next   = ptr_reg + IDX_W'(1);
                                state_next = S_SH_READ;
                            end
                        end
                        else
                        begin
                            res_status_next = uidwl_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_status_next = uidwl_pkg::ST_OK;
                    end
                endcase
            end

            S_SH_READ:
            begin
                state_next = S_SH_WRITE;
            end

            S_SH_WRITE:
            begin
                // Move the entry just read down one slot
                wr_en   = 1'b1;
                wr_addr = ptr_reg - IDX_W'(1);
                wr_data = rd_data_reg;
                if (last)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_reg + IDX_W'(1);
                    state_next = S_SH_READ;
                end
            end

            S_DONE:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = uidwl_pkg::INDEX_W'(res_index_reg);
                    out_count_next  = uidwl_pkg::COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        hit_reg        <= hit_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
        if (accept)
        begin
            cmd_reg       <= uidwl_pkg::cmd_t'(request.command);
            item_reg.len  <= request.uid_length;
            item_reg.low  <= request.uid_low;
            item_reg.high <= request.uid_high;
        end
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    assign response.valid       = out_valid_reg;
    assign response.status      = out_status_reg;
    assign response.entry_index = out_index_reg;
    assign response.entry_count = out_count_reg;

endmodule

// ===== rtl/core/uidwl_checker.sv =====
// ============================================================================
// uidwl_checker
// Port-level checks of the identifier table, bound to the top level.
// ============================================================================
module uidwl_checker #(
    parameter int CAPACITY = uidwl_pkg::DEF_CAPACITY
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [uidwl_pkg::STATUS_W-1:0] rsp_status,
    input logic [uidwl_pkg::INDEX_W-1:0]  rsp_index,
    input logic [uidwl_pkg::COUNT_W-1:0]  rsp_count
);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // The table is busy right after taking a command
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // Results without a slot report index zero
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != uidwl_pkg::ST_OK) |-> rsp_index == '0)
        else $error("nonzero index on failed command");

    // The count never exceeds the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY > 31) || (int'(rsp_count) <= CAPACITY))
        else $error("entry count above capacity");

endmodule

bind uid_whitelist_table uidwl_checker #(
    .CAPACITY (CAPACITY)
) u_uidwl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .rsp_valid  (response.valid),
    .rsp_ready  (response.ready),
    .rsp_status (response.status),
    .rsp_index  (response.entry_index),
    .rsp_count  (response.entry_count)
);
